### rtl/swnd_pkg.sv
// ============================================================================
// swnd_pkg - shared definitions for the sliding window sender
// Sizes, field offsets, operation and result codes, pointer helpers and the
// command and status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package swnd_pkg;

    // Sizing of the send ring, the sequence space and the chunk.
    localparam int BUFFER_DEPTH = 16;
    localparam int SEQ_SPACE    = 256;
    localparam int CHUNK_BITS   = 32;
    localparam int MAX_RES      = 16;

    localparam int PTR_SPACE = 2 * BUFFER_DEPTH;
    localparam int PTR_W     = $clog2(PTR_SPACE);
    localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
    localparam int SEQ_W     = 8;
    localparam int RSEQ_W    = 9;
    localparam int WIN_W     = 5;
    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int CMP_W0    = (PTR_W > WIN_W) ? PTR_W : WIN_W;
    localparam int CMP_W     = (CMP_W0 > CNT_W) ? CMP_W0 : CNT_W;

    // Input item layout: chunk, resp_seq, resp_is_ack, resp_window.
    localparam int IN_CHUNK_LSB = 0;
    localparam int IN_RSEQ_LSB  = IN_CHUNK_LSB + CHUNK_BITS;
    localparam int IN_RACK_LSB  = IN_RSEQ_LSB + RSEQ_W;
    localparam int IN_RWIN_LSB  = IN_RACK_LSB + 1;
    localparam int IN_BITS      = IN_RWIN_LSB + WIN_W;
    localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Result item layout: pkt_seq, pkt_data, refused, done_res.
    localparam int OUT_SEQ_LSB  = 0;
    localparam int OUT_DATA_LSB = OUT_SEQ_LSB + RSEQ_W;
    localparam int OUT_REF_LSB  = OUT_DATA_LSB + CHUNK_BITS;
    localparam int OUT_DONE_LSB = OUT_REF_LSB + 1;
    localparam int OUT_BITS     = OUT_DONE_LSB + 1;
    localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_END    = 2'd1,
        OP_RESP   = 2'd2,
        OP_SEND   = 2'd3
    } op_t;

    // Result kinds carried in m_tuser.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_PROBE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Sequence value that marks a probe and a probe response.
    localparam logic [RSEQ_W-1:0] PROBE_SEQ = '1;

    // Controller to datapath.
    typedef struct packed {
        logic take_item;   // execute the item on the input port
        logic emit_pkt;    // send the next buffered chunk
    } swnd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register can be loaded this cycle
        logic send_burst;  // the input item is a send that starts a burst
        logic last_pkt;    // one packet of the burst is left
    } swnd_status_t;

    // Distance from b to a on the wrapping pointer ring.
    function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + (PTR_W + 1)'(PTR_SPACE) - {1'b0, b};
        end
        return t[PTR_W-1:0];
    endfunction

    // Pointer plus one, wrapping at the pointer space.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a == PTR_W'(PTR_SPACE - 1)) begin
            r = '0;
        end else begin
            r = a + PTR_W'(1);
        end
        return r;
    endfunction

    // Ring slot addressed by a pointer.
    function automatic logic [ADDR_W-1:0] ptr_addr(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a >= PTR_W'(BUFFER_DEPTH)) begin
            r = a - PTR_W'(BUFFER_DEPTH);
        end else begin
            r = a;
        end
        return r[ADDR_W-1:0];
    endfunction

    // Sequence number plus one, wrapping at the sequence space.
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
        logic [SEQ_W-1:0] r;
        if (a == SEQ_W'(SEQ_SPACE - 1)) begin
            r = '0;
        end else begin
            r = a + SEQ_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/swnd_ram.sv
// ============================================================================
// swnd_ram - generic single write, single read RAM
// One write port and one read port with a registered read.
// ============================================================================
`default_nettype none

module swnd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/swnd_ctrl.sv
// ============================================================================
// swnd_ctrl - sequencer of the sliding window sender
// Takes input items and paces a send burst through the ring read and the
// output register, one packet at a time.
// ============================================================================
`default_nettype none

module swnd_ctrl
    import swnd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire swnd_status_t status,
    output swnd_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.emit_pkt  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free) begin
                    cmd.take_item = 1'b1;
                    if (status.send_burst) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // The ring read of the next chunk lands at this edge.
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_pkt = 1'b1;
                    state_next   = status.last_pkt ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/swnd_dp.sv
// ============================================================================
// swnd_dp - datapath of the sliding window sender
// Ring buffer, window pointers, sequence numbers, burst counter and the
// output register that holds one result item.
// ============================================================================
`default_nettype none

module swnd_dp
    import swnd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire swnd_cmd_t            cmd,
    output swnd_status_t              status,
    input  wire logic [1:0]           s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic                      m_tlast,
    output logic      [1:0]           m_tuser,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    // Window state.
    logic [PTR_W-1:0]  acked_reg,    acked_next;
    logic [PTR_W-1:0]  sent_reg,     sent_next;
    logic [PTR_W-1:0]  written_reg,  written_next;
    logic [SEQ_W-1:0]  seq_reg,      seq_next;
    logic [SEQ_W-1:0]  expected_reg, expected_next;
    logic [WIN_W-1:0]  window_reg,   window_next;
    logic              ended_reg,    ended_next;
    logic [CNT_W-1:0]  burst_reg,    burst_next;

    // Output register.
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [RSEQ_W-1:0] out_seq_reg;
    logic [CHUNK_BITS-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_refused_reg;
    logic              out_done_reg;

    // Values loaded into the output register.
    logic              load_out;
    logic [1:0]        ld_kind;
    logic [RSEQ_W-1:0] ld_seq;
    logic [CHUNK_BITS-1:0] ld_data;
    logic              ld_last;
    logic              ld_refused;
    logic              ld_done;

    // Input fields.
    op_t                   in_op;
    logic [CHUNK_BITS-1:0] in_chunk;
    logic [RSEQ_W-1:0]     in_rseq;
    logic                  in_rack;
    logic [WIN_W-1:0]      in_rwin;

    // Ring access and burst sizing.
    logic                  ram_we;
    logic [CHUNK_BITS-1:0] ram_rd_data;
    logic [PTR_W-1:0]      inflight;
    logic [PTR_W-1:0]      unsent;
    logic [CMP_W-1:0]      avail;
    logic [CMP_W-1:0]      cnt_pre;
    logic [CNT_W-1:0]      burst_cnt;
    logic                  ring_full;
    logic                  win_zero;
    logic                  cnt_zero;
    logic                  in_order;
    logic                  done_now;
    logic                  out_free;

    assign in_op    = op_t'(s_tuser);
    assign in_chunk = s_tdata[IN_CHUNK_LSB +: CHUNK_BITS];
    assign in_rseq  = s_tdata[IN_RSEQ_LSB +: RSEQ_W];
    assign in_rack  = s_tdata[IN_RACK_LSB];
    assign in_rwin  = s_tdata[IN_RWIN_LSB +: WIN_W];

    // Send ring: appends write at the written pointer, sends read at the sent one.
    swnd_ram #(
        .WIDTH(CHUNK_BITS),
        .DEPTH(BUFFER_DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ptr_addr(written_reg)),
        .wr_data(in_chunk),
        .rd_addr(ptr_addr(sent_reg)),
        .rd_data(ram_rd_data)
    );

    // Occupancy and the size of a send burst.
    always_comb begin
        inflight  = ptr_diff(sent_reg, acked_reg);
        unsent    = ptr_diff(written_reg, sent_reg);
        ring_full = ptr_diff(written_reg, acked_reg) >= PTR_W'(BUFFER_DEPTH);
        if (CMP_W'(window_reg) > CMP_W'(inflight)) begin
            avail = CMP_W'(window_reg) - CMP_W'(inflight);
        end else begin
            avail = '0;
        end
        cnt_pre = (CMP_W'(unsent) < avail) ? CMP_W'(unsent) : avail;
        if (cnt_pre > CMP_W'(MAX_RES)) begin
            burst_cnt = CNT_W'(MAX_RES);
        end else begin
            burst_cnt = cnt_pre[CNT_W-1:0];
        end
        win_zero = (window_reg == '0);
        cnt_zero = (burst_cnt == '0);
        in_order = !in_rseq[RSEQ_W-1] && (in_rseq[SEQ_W-1:0] == expected_reg);
    end

    // Item execution and packet emission.
    always_comb begin
        acked_next    = acked_reg;
        sent_next     = sent_reg;
        written_next  = written_reg;
        seq_next      = seq_reg;
        expected_next = expected_reg;
        window_next   = window_reg;
        ended_next    = ended_reg;
        burst_next    = burst_reg;
        ram_we        = 1'b0;
        load_out      = 1'b0;
        ld_kind       = KIND_STATUS;
        ld_seq        = '0;
        ld_data       = '0;
        ld_last       = 1'b1;
        ld_refused    = 1'b0;
        if (cmd.take_item) begin
            case (in_op)
                OP_APPEND: begin
                    load_out   = 1'b1;
                    ld_refused = ring_full;
                    if (!ring_full) begin
                        ram_we       = 1'b1;
                        written_next = ptr_inc(written_reg);
                    end
                end
                OP_END: begin
                    load_out   = 1'b1;
                    ended_next = 1'b1;
                end
                OP_RESP: begin
                    load_out = 1'b1;
                    if (in_rseq == PROBE_SEQ) begin
                        window_next = in_rwin;
                    end else if (in_order) begin
                        if (in_rack) begin
                            // An ACK with nothing in flight changes nothing.
                            if (acked_reg != sent_reg) begin
                                window_next   = in_rwin;
                                expected_next = seq_inc(expected_reg);
                                acked_next    = ptr_inc(acked_reg);
                            end
                        end else begin
                            // Go back: resend from the oldest unacked chunk.
                            sent_next = acked_reg;
                            seq_next  = expected_reg;
                        end
                    end
                end
                OP_SEND: begin
                    if (win_zero) begin
                        load_out = 1'b1;
                        ld_kind  = KIND_PROBE;
                        ld_seq   = PROBE_SEQ;
                    end else if (cnt_zero) begin
                        load_out = 1'b1;
                    end else begin
                        burst_next = burst_cnt;
                    end
                end
                default: begin
                    load_out = 1'b0;
                end
            endcase
        end else if (cmd.emit_pkt) begin
            load_out   = 1'b1;
            ld_kind    = KIND_DATA;
            ld_seq     = {1'b0, seq_reg};
            ld_data    = ram_rd_data;
            ld_last    = (burst_reg == CNT_W'(1));
            sent_next  = ptr_inc(sent_reg);
            seq_next   = seq_inc(seq_reg);
            burst_next = burst_reg - CNT_W'(1);
        end
    end

    // Completion after this item's updates.
    assign done_now = ended_next && (acked_next == sent_next) && (sent_next == written_next);

    // A burst always leaves packets in flight, so done stays low on its packets.
    assign ld_done = cmd.emit_pkt ? 1'b0 : done_now;

    assign out_free = !out_valid_reg || m_tready;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acked_reg     <= '0;
            sent_reg      <= '0;
            written_reg   <= '0;
            seq_reg       <= '0;
            expected_reg  <= '0;
            window_reg    <= '0;
            ended_reg     <= 1'b0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acked_reg     <= acked_next;
            sent_reg      <= sent_next;
            written_reg   <= written_next;
            seq_reg       <= seq_next;
            expected_reg  <= expected_next;
            window_reg    <= window_next;
            ended_reg     <= ended_next;
            burst_reg     <= burst_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_kind_reg    <= ld_kind;
            out_seq_reg     <= ld_seq;
            out_data_reg    <= ld_data;
            out_last_reg    <= ld_last;
            out_refused_reg <= ld_refused;
            out_done_reg    <= ld_done;
        end
    end

    assign status.out_free   = out_free;
    assign status.send_burst = (in_op == OP_SEND) && !win_zero && !cnt_zero;
    assign status.last_pkt   = (burst_reg == CNT_W'(1));

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(M_TDATA_W - OUT_BITS)'(0), out_done_reg, out_refused_reg,
                       out_data_reg, out_seq_reg};

endmodule

`default_nettype wire

### rtl/sliding_window_sender.sv
// ============================================================================
// sliding_window_sender - go-back-N sliding window sender
// Ring send buffer, receiver-advertised window, probes and go-back rewind.
// ============================================================================
// Each input item is an operation in s_tuser (append chunk, end of data,
// response, send opportunity). Append, end-of-data and response items each
// give one status item. A send opportunity gives a probe when the advertised
// window is zero, a status item when nothing fits or remains, and otherwise
// a burst of n data packets (n up to 16): each packet waits for the registered
// read of the send ring and then until the single output register is free to
// load. A new input item is taken while the last result still waits, as long
// as the output register drains in the same cycle. The last item caused by an
// input carries m_tlast. No clearing pass follows reset.
// ============================================================================
`default_nettype none

module sliding_window_sender
    import swnd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: chunk, resp_seq, resp_is_ack, resp_window, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // tuser: operation
    input  wire logic [1:0]           s_tuser,
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata: pkt_seq, pkt_data, refused, done_res, zero pad
    output logic      [M_TDATA_W-1:0] m_tdata,
    // tuser: kind
    output logic      [1:0]           m_tuser,
    output logic                      m_tlast
);

    swnd_cmd_t    cmd;
    swnd_status_t status;

    // Sequencer.
    swnd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Buffer, window state and output register.
    swnd_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

### verif/sliding_window_sender_test.sv
// ============================================================================
// sliding_window_sender_test - self-checking bench for the go-back-N sender
// A mirror of the sender state predicts every result item of each accepted
// input item. Directed items cover probes, rewinds, ignored responses, end of
// data and completion; random exchanges then fill the ring, open wide windows
// and acknowledge bursts in order while both sides stall at random.
// ============================================================================
`timescale 1ns / 100ps

module sliding_window_sender_test;
    import swnd_pkg::*;

    localparam int RANDOM_ITEMS   = 185;
    localparam int CALM_TAIL      = 25;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result item as the block should present it.
    typedef struct {
        logic [1:0]            kind;
        logic [RSEQ_W-1:0]     seq;
        logic [CHUNK_BITS-1:0] data;
        logic                  last;
        logic                  refused;
        logic                  done;
    } pkt_rec_t;

    // Mirror of the sender: ring, pointers, sequence numbers and window.
    class sender_mirror;
        logic [CHUNK_BITS-1:0] ring [BUFFER_DEPTH];
        logic [PTR_W-1:0]      acked_ptr;
        logic [PTR_W-1:0]      sent_ptr;
        logic [PTR_W-1:0]      written_ptr;
        logic [SEQ_W-1:0]      next_seq;
        logic [SEQ_W-1:0]      oldest_seq;
        logic [WIN_W-1:0]      adv_window;
        bit                    data_ended;
        pkt_rec_t              pending_pkts[$];
        int                    errors;
        int                    results_seen;

        function new();
            acked_ptr    = '0;
            sent_ptr     = '0;
            written_ptr  = '0;
            next_seq     = '0;
            oldest_seq   = '0;
            adv_window   = '0;
            data_ended   = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Distance from b to a on the wrapping pointer ring.
        function int ring_gap(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b);
            logic [PTR_W-1:0] d;
            d = a - b;
            return int'(d);
        endfunction

        function int in_flight();
            return ring_gap(sent_ptr, acked_ptr);
        endfunction

        function int unsent();
            return ring_gap(written_ptr, sent_ptr);
        endfunction

        function bit ring_full();
            return ring_gap(written_ptr, acked_ptr) >= BUFFER_DEPTH;
        endfunction

        function bit all_done();
            return data_ended && acked_ptr == sent_ptr && sent_ptr == written_ptr;
        endfunction

        // Update the mirror with one accepted item and queue its results.
        function void apply_item(op_t op, logic [CHUNK_BITS-1:0] chunk,
                                 logic [RSEQ_W-1:0] rseq, logic rack,
                                 logic [WIN_W-1:0] rwin);
            pkt_rec_t out_q[$];
            pkt_rec_t rec;
            int       cnt;
            rec = '{KIND_STATUS, '0, '0, 1'b0, 1'b0, 1'b0};
            case (op)
                OP_APPEND: begin
                    if (ring_full()) begin
                        rec.refused = 1'b1;
                    end else begin
                        ring[written_ptr[ADDR_W-1:0]] = chunk;
                        written_ptr = written_ptr + PTR_W'(1);
                    end
                    out_q.push_back(rec);
                end
                OP_END: begin
                    data_ended = 1'b1;
                    out_q.push_back(rec);
                end
                OP_RESP: begin
                    if (rseq == PROBE_SEQ) begin
                        adv_window = rwin;
                    end else if (!rseq[RSEQ_W-1] && rseq[SEQ_W-1:0] == oldest_seq) begin
                        if (rack) begin
                            // An in-order ACK with nothing in flight changes nothing.
                            if (acked_ptr != sent_ptr) begin
                                adv_window = rwin;
                                oldest_seq = oldest_seq + SEQ_W'(1);
                                acked_ptr  = acked_ptr + PTR_W'(1);
                            end
                        end else begin
                            sent_ptr = acked_ptr;
                            next_seq = oldest_seq;
                        end
                    end
                    out_q.push_back(rec);
                end
                default: begin
                    if (adv_window == '0) begin
                        rec.kind = KIND_PROBE;
                        rec.seq  = PROBE_SEQ;
                        out_q.push_back(rec);
                    end else begin
                        cnt = (int'(adv_window) > in_flight()) ?
                              int'(adv_window) - in_flight() : 0;
                        if (unsent() < cnt) cnt = unsent();
                        if (cnt > MAX_RES) cnt = MAX_RES;
                        for (int k = 0; k < cnt; k++) begin
                            rec.kind = KIND_DATA;
                            rec.seq  = {1'b0, next_seq};
                            rec.data = ring[sent_ptr[ADDR_W-1:0]];
                            out_q.push_back(rec);
                            sent_ptr = sent_ptr + PTR_W'(1);
                            next_seq = next_seq + SEQ_W'(1);
                        end
                        // Window open but nothing fits or remains.
                        if (cnt == 0) out_q.push_back(rec);
                    end
                end
            endcase
            foreach (out_q[k]) begin
                out_q[k].done = all_done();
                out_q[k].last = (k == out_q.size() - 1);
                pending_pkts.push_back(out_q[k]);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [CHUNK_BITS-1:0] got,
                         logic [CHUNK_BITS-1:0] want);
            if (got !== want) begin
                report($sformatf("result %0d field %s is %0h, expected %0h",
                                 results_seen, name, got, want));
            end
        endtask

        // Compare one accepted result with the oldest expectation.
        task match_result(pkt_rec_t got);
            pkt_rec_t want;
            if (pending_pkts.size() == 0) begin
                report($sformatf("result %0d (kind %0d, seq %0h) with nothing expected",
                                 results_seen, got.kind, got.seq));
            end else begin
                want = pending_pkts.pop_front();
                check_field("kind", CHUNK_BITS'(got.kind), CHUNK_BITS'(want.kind));
                check_field("pkt_seq", CHUNK_BITS'(got.seq), CHUNK_BITS'(want.seq));
                check_field("pkt_data", got.data, want.data);
                check_field("last", CHUNK_BITS'(got.last), CHUNK_BITS'(want.last));
                check_field("refused", CHUNK_BITS'(got.refused),
                            CHUNK_BITS'(want.refused));
                check_field("done_res", CHUNK_BITS'(got.done), CHUNK_BITS'(want.done));
            end
            results_seen++;
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    sender_mirror mirror = new();
    bit           gaps_on = 1'b1;
    int           items_done = 0;
    int           tx_calm = 0;
    int           idle_cycles = 0;

    sliding_window_sender dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock: 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sliding_window_sender_test NOT OK");
            $finish;
        end
    end

    function automatic logic [CHUNK_BITS-1:0] pick_chunk();
        int r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Mostly ordinary windows, sometimes closed or beyond the ring depth.
    function automatic logic [WIN_W-1:0] pick_window();
        int r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return WIN_W'($urandom_range(17, 31));
        return WIN_W'($urandom_range(1, 16));
    endfunction

    function automatic logic [RSEQ_W-1:0] pick_rseq();
        int r = $urandom_range(0, 5);
        if (r == 0) return PROBE_SEQ;
        if (r < 3) return {1'b0, mirror.oldest_seq};
        if (r == 3) return {1'b0, mirror.oldest_seq + 8'd1};
        return RSEQ_W'($urandom_range(0, 511));
    endfunction

    // Present one input item and wait until it is accepted.
    task automatic issue(op_t op, logic [CHUNK_BITS-1:0] chunk, logic [RSEQ_W-1:0] rseq,
                         logic rack, logic [WIN_W-1:0] rwin);
        if (gaps_on && tx_calm == 0 && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        if (tx_calm > 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 24) == 0) begin
            tx_calm = $urandom_range(8, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // Fields from bit 0 up: chunk, resp_seq, resp_is_ack, resp_window.
        s_tdata  <= S_TDATA_W'({rwin, rack, rseq, chunk});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.apply_item(op, chunk, rseq, rack, rwin);
        items_done++;
    endtask

    task automatic do_append(logic [CHUNK_BITS-1:0] chunk);
        issue(OP_APPEND, chunk, RSEQ_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
              WIN_W'($urandom_range(0, 31)));
    endtask

    task automatic do_end();
        issue(OP_END, $urandom, RSEQ_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
              WIN_W'($urandom_range(0, 31)));
    endtask

    task automatic do_resp(logic [RSEQ_W-1:0] rseq, logic rack, logic [WIN_W-1:0] rwin);
        issue(OP_RESP, $urandom, rseq, rack, rwin);
    endtask

    task automatic do_send();
        issue(OP_SEND, $urandom, RSEQ_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
              WIN_W'($urandom_range(0, 31)));
    endtask

    // Acknowledge what is in flight in order, now and then with a NACK instead.
    task automatic ack_outstanding();
        int n;
        n = mirror.in_flight();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                do_resp({1'b0, mirror.oldest_seq}, 1'b0, pick_window());
                break;
            end
            do_resp({1'b0, mirror.oldest_seq}, 1'b1, pick_window());
        end
    endtask

    // Result side: check accepted items and stall in short random bursts.
    initial begin
        pkt_rec_t got;
        int       stall_left;
        int       calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.seq     = m_tdata[OUT_SEQ_LSB +: RSEQ_W];
                got.data    = m_tdata[OUT_DATA_LSB +: CHUNK_BITS];
                got.refused = m_tdata[OUT_REF_LSB];
                got.done    = m_tdata[OUT_DONE_LSB];
                got.last    = m_tlast;
                mirror.match_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!gaps_on || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                calm_left = $urandom_range(10, 40);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Input side: reset, directed items, random exchanges, then the verdict.
    initial begin
        int stop_at;
        int scenario;
        int r;
        int rounds;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_APPEND;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Probes while the window is closed, then an open window with no data.
        do_send();
        do_resp(PROBE_SEQ, 1'b0, 5'd0);
        do_send();
        do_resp(PROBE_SEQ, 1'b1, 5'd2);
        do_send();
        // In-order ACK while nothing is in flight is ignored.
        do_resp(9'd0, 1'b1, 5'd5);
        do_append('0);
        do_append('1);
        do_append(32'hA5C3_0F96);
        do_send();
        // Out-of-order and negative sequence numbers are ignored.
        do_resp(9'd7, 1'b1, 5'd9);
        do_resp(9'h1FE, 1'b1, 5'd9);
        do_resp(9'h100, 1'b0, 5'd9);
        // Window wider than the ring, then a NACK that goes back.
        do_resp(9'd0, 1'b1, 5'd31);
        do_resp(9'd1, 1'b0, 5'd0);
        do_send();
        // End of data, an append after it, and acknowledgment up to completion.
        do_end();
        do_append($urandom);
        do_send();
        repeat (3) do_resp({1'b0, mirror.oldest_seq}, 1'b1, 5'd16);
        do_send();
        do_resp(PROBE_SEQ, 1'b1, 5'd0);
        do_send();

        stop_at = items_done + RANDOM_ITEMS;
        while (items_done < stop_at) begin
            gaps_on  = (items_done < stop_at - CALM_TAIL);
            scenario = $urandom_range(0, 99);
            if (scenario < 30) begin
                // One item of any operation with random fields.
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    do_append(pick_chunk());
                end else if (r == 3) begin
                    do_end();
                end else if (r < 7) begin
                    do_resp(pick_rseq(), 1'($urandom_range(0, 1)), pick_window());
                end else begin
                    do_send();
                end
            end else if (scenario < 42) begin
                // Fill the ring, hit the refusal, rewind and send a full burst.
                while (!mirror.ring_full()) do_append(pick_chunk());
                do_append(pick_chunk());
                do_resp({1'b0, mirror.oldest_seq}, 1'b0, pick_window());
                do_resp(PROBE_SEQ, 1'($urandom_range(0, 1)), WIN_W'($urandom_range(16, 31)));
                do_send();
                ack_outstanding();
            end else if (scenario < 72) begin
                do_send();
                ack_outstanding();
            end else if (scenario < 82) begin
                do_resp(PROBE_SEQ, 1'($urandom_range(0, 1)), pick_window());
                do_send();
            end else if (scenario < 94) begin
                repeat ($urandom_range(1, 4)) do_append(pick_chunk());
                do_send();
            end else begin
                // End of data, then exchange until everything is acknowledged or 20 rounds pass.
                do_end();
                rounds = 0;
                while (!mirror.all_done() && rounds < 20) begin
                    if (mirror.adv_window == '0) begin
                        do_resp(PROBE_SEQ, 1'($urandom_range(0, 1)),
                                WIN_W'($urandom_range(1, 31)));
                    end
                    do_send();
                    ack_outstanding();
                    rounds++;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for a late burst before the verdict.
        while (mirror.pending_pkts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mirror.errors == 0) begin
            $display("sliding_window_sender_test OK");
        end else begin
            $display("sliding_window_sender_test NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/swnd_pkg.sv
rtl/swnd_ram.sv
rtl/swnd_ctrl.sv
rtl/swnd_dp.sv
rtl/sliding_window_sender.sv
verif/sliding_window_sender_test.sv
